// ===== rtl/cgb_pkg.sv =====
// shared constants for the central gravity and bounce block
package cgb_pkg;

  localparam int STRENGTH_W = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = STRENGTH_W;

  localparam logic [CFG_IDX_W-1:0] CFG_CENTRAL_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CONST_GX     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CONST_GY     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CORE_RADIUS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STRENGTH     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y     = 3'd6;

  localparam logic [31:0] CONST_GY_RST    = 32'd5120;
  localparam logic [31:0] CORE_RADIUS_RST = 32'd12800;
  localparam logic [31:0] STRENGTH_RST    = 32'd10000000;
  localparam logic [31:0] CENTER_X_RST    = 32'd102400;
  localparam logic [31:0] CENTER_Y_RST    = 32'd76800;

endpackage

// ===== rtl/cgb_in_if.sv =====
// ball input channel
interface cgb_in_if #(
  parameter int WORD_WIDTH = 24
);
  logic                         valid;
  logic                         ready;
  logic signed [WORD_WIDTH-1:0] ball_x;
  logic signed [WORD_WIDTH-1:0] ball_y;
  logic signed [WORD_WIDTH-1:0] ball_vx;
  logic signed [WORD_WIDTH-1:0] ball_vy;
  logic [WORD_WIDTH-2:0]        ball_radius;
  logic                         last_ball;

  modport source (
    output valid, ball_x, ball_y, ball_vx, ball_vy, ball_radius, last_ball,
    input  ready
  );
  modport sink (
    input  valid, ball_x, ball_y, ball_vx, ball_vy, ball_radius, last_ball,
    output ready
  );
endinterface

// ===== rtl/cgb_out_if.sv =====
// result channel
interface cgb_out_if #(
  parameter int WORD_WIDTH = 24
);
  logic                         valid;
  logic                         ready;
  logic signed [WORD_WIDTH-1:0] accel_x;
  logic signed [WORD_WIDTH-1:0] accel_y;
  logic signed [WORD_WIDTH-1:0] out_vx;
  logic signed [WORD_WIDTH-1:0] out_vy;
  logic                         bounced;
  logic                         inside_core;
  logic                         saturated;
  logic                         last_out;

  modport source (
    output valid, accel_x, accel_y, out_vx, out_vy, bounced, inside_core, saturated,
           last_out,
    input  ready
  );
  modport sink (
    input  valid, accel_x, accel_y, out_vx, out_vy, bounced, inside_core, saturated,
           last_out,
    output ready
  );
endinterface

// ===== rtl/cgb_div.sv =====
// pipelined restoring divider, one quotient bit per stage, with overflow flag
module cgb_div #(
  parameter int NUM_W = 80,
  parameter int DEN_W = 75,
  parameter int QUO_W = 25
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [QUO_W-1:0] quo,
  output logic             ovf
);

  localparam int XW = ((NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W) + 1;

  logic [XW-1:0]    rem_r [0:QUO_W];
  logic [DEN_W-1:0] den_r [0:QUO_W];
  logic [QUO_W-1:0] quo_r [0:QUO_W];
  logic             ovf_r [0:QUO_W];
  logic [XW-1:0]    sh    [0:QUO_W-1];
  logic [QUO_W-1:0] ge;

  always_comb begin
    for (int k = 0; k < QUO_W; k++) begin
      sh[k] = XW'(den_r[k]) << (QUO_W - 1 - k);
      ge[k] = rem_r[k] >= sh[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= XW'(num);
      den_r[0] <= den;
      quo_r[0] <= '0;
      ovf_r[0] <= XW'(num) >= (XW'(den) << QUO_W);
      for (int k = 0; k < QUO_W; k++) begin
        rem_r[k+1] <= ge[k] ? rem_r[k] - sh[k] : rem_r[k];
        den_r[k+1] <= den_r[k];
        quo_r[k+1] <= quo_r[k] | (QUO_W'(ge[k]) << (QUO_W - 1 - k));
        ovf_r[k+1] <= ovf_r[k];
      end
    end
  end

  assign quo = quo_r[QUO_W];
  assign ovf = ovf_r[QUO_W];

endmodule

// ===== rtl/central_gravity_and_bounce.sv =====
// Gravity and core bounce for one ball per transaction. Fully pipelined: a ball
// can be accepted every cycle unless the pipeline holds. Most of its depth comes
// from the square root, which resolves one root bit per stage, and from the
// dividers for the acceleration and the reflection, which resolve one quotient
// bit per stage. When the result register is full and not taken, the whole
// pipeline holds and in_ch.ready drops.
// Configuration writes take effect at once and are meant for an empty pipeline.
module central_gravity_and_bounce
  import cgb_pkg::*;
#(
  parameter int WORD_WIDTH = 24,
  parameter int FRAC_BITS  = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  cgb_in_if.sink                in_ch,
  cgb_out_if.source             out_ch
);

  localparam int W   = WORD_WIDTH;
  localparam int SW  = STRENGTH_W;
  localparam int RW  = W + 1;
  localparam int QW  = W + 1;
  localparam int R2W = 2 * W + 1;
  localparam int CW  = 2 * W + 3;
  localparam int NAW = SW + W + 3 * FRAC_BITS;
  localparam int NRW = 3 * W + 1;
  localparam int LAT = 9 + RW + QW;

  localparam logic [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

  typedef struct packed {
    logic signed [W-1:0] vx;
    logic signed [W-1:0] vy;
    logic                x_neg;
    logic                y_neg;
    logic                x_pos;
    logic                y_pos;
    logic                in_core;
    logic                bounce;
    logic                last;
  } side_t;

  typedef struct packed {
    logic [R2W-1:0] r2;
    logic [2*W-1:0] fm;
    logic [W-1:0]   adx;
    logic [W-1:0]   ady;
    side_t          side;
  } sq_t;

  typedef struct packed {
    logic [W-1:0] val;
    logic         sat;
  } satv_t;

  // configuration registers
  logic                central_mode_r;
  logic signed [W-1:0] const_gx_r;
  logic signed [W-1:0] const_gy_r;
  logic [W-2:0]        core_radius_r;
  logic [SW-1:0]       strength_r;
  logic [W-2:0]        center_x_r;
  logic [W-2:0]        center_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      central_mode_r <= 1'b0;
      const_gx_r     <= '0;
      const_gy_r     <= W'(CONST_GY_RST);
      core_radius_r  <= (W-1)'(CORE_RADIUS_RST);
      strength_r     <= SW'(STRENGTH_RST);
      center_x_r     <= (W-1)'(CENTER_X_RST);
      center_y_r     <= (W-1)'(CENTER_Y_RST);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CENTRAL_MODE: central_mode_r <= cfg_wdata[0];
        CFG_CONST_GX:     const_gx_r     <= cfg_wdata[W-1:0];
        CFG_CONST_GY:     const_gy_r     <= cfg_wdata[W-1:0];
        CFG_CORE_RADIUS:  core_radius_r  <= cfg_wdata[W-2:0];
        CFG_STRENGTH:     strength_r     <= cfg_wdata[SW-1:0];
        CFG_CENTER_X:     center_x_r     <= cfg_wdata[W-2:0];
        CFG_CENTER_Y:     center_y_r     <= cfg_wdata[W-2:0];
        default: ;
      endcase
    end
  end

  // flow control
  logic           adv;
  logic           out_valid;
  logic [LAT-1:0] vld_r;

  assign out_valid   = vld_r[LAT-1];
  assign adv         = !out_valid || out_ch.ready;
  assign in_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LAT-2:0], in_ch.valid};
    end
  end

  // stage 1: offsets from the centre
  logic signed [W:0]   dx1_r, dy1_r;
  logic signed [W-1:0] vx1_r, vy1_r;
  logic [W-1:0]        rr1_r;
  logic                last1_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      dx1_r   <= {2'b00, center_x_r} - {in_ch.ball_x[W-1], in_ch.ball_x};
      dy1_r   <= {2'b00, center_y_r} - {in_ch.ball_y[W-1], in_ch.ball_y};
      vx1_r   <= in_ch.ball_vx;
      vy1_r   <= in_ch.ball_vy;
      rr1_r   <= {1'b0, in_ch.ball_radius} + {1'b0, core_radius_r};
      last1_r <= in_ch.last_ball;
    end
  end

  // stage 2: squares and velocity products
  logic signed [W:0]     ex, ey;
  logic [W:0]            dxm, dym;
  logic [2*W-1:0]        adx2_r, ady2_r, rr2_r;
  logic [2*W-3:0]        core2_r;
  logic signed [2*W:0]   pvx_r, pvy_r;
  logic [W-1:0]          adx2m_r, ady2m_r;
  side_t                 side2_r;

  assign ex  = -dx1_r;
  assign ey  = -dy1_r;
  assign dxm = dx1_r[W] ? ex : dx1_r;
  assign dym = dy1_r[W] ? ey : dy1_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      adx2_r          <= dxm[W-1:0] * dxm[W-1:0];
      ady2_r          <= dym[W-1:0] * dym[W-1:0];
      pvx_r           <= vx1_r * ex;
      pvy_r           <= vy1_r * ey;
      rr2_r           <= rr1_r * rr1_r;
      core2_r         <= core_radius_r * core_radius_r;
      adx2m_r         <= dxm[W-1:0];
      ady2m_r         <= dym[W-1:0];
      side2_r.vx      <= vx1_r;
      side2_r.vy      <= vy1_r;
      side2_r.x_neg   <= dx1_r[W];
      side2_r.y_neg   <= dy1_r[W];
      side2_r.x_pos   <= !dx1_r[W] && (dx1_r != '0);
      side2_r.y_pos   <= !dy1_r[W] && (dy1_r != '0);
      side2_r.in_core <= 1'b0;
      side2_r.bounce  <= 1'b0;
      side2_r.last    <= last1_r;
    end
  end

  // stage 3: squared distance and v.d
  logic [R2W-1:0]        r2_r;
  logic signed [2*W+1:0] f_r;
  logic [2*W-1:0]        rr2_3_r;
  logic [2*W-3:0]        core2_3_r;
  logic [W-1:0]          adx3_r, ady3_r;
  side_t                 side3_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      r2_r      <= {1'b0, adx2_r} + {1'b0, ady2_r};
      f_r       <= pvx_r + pvy_r;
      rr2_3_r   <= rr2_r;
      core2_3_r <= core2_r;
      adx3_r    <= adx2m_r;
      ady3_r    <= ady2m_r;
      side3_r   <= side2_r;
    end
  end

  // stage 4 and square root stages
  logic signed [2*W+1:0] fneg;
  logic signed [2*W+1:0] fmag;
  logic                  inside4, bounce4;
  logic [CW-1:0]         rem_r [0:RW];
  logic [RW-1:0]         res_r [0:RW];
  sq_t                   sq_r  [0:RW];
  logic [CW-1:0]         cand  [0:RW-1];
  logic [RW-1:0]         take;
  sq_t                   sq4;

  assign fneg    = -f_r;
  assign fmag    = f_r[2*W+1] ? fneg : f_r;
  assign inside4 = central_mode_r &&
                   ((r2_r < R2W'(core2_3_r)) || (r2_r == '0));
  assign bounce4 = central_mode_r && (R2W'(rr2_3_r) >= r2_r) &&
                   f_r[2*W+1] && (r2_r != '0);

  always_comb begin
    sq4              = '0;
    sq4.r2           = r2_r;
    sq4.fm           = fmag[2*W-1:0];
    sq4.adx          = adx3_r;
    sq4.ady          = ady3_r;
    sq4.side         = side3_r;
    sq4.side.in_core = inside4;
    sq4.side.bounce  = bounce4;
    for (int k = 0; k < RW; k++) begin
      cand[k] = (CW'(res_r[k]) << (RW - k)) | (CW'(1) << (2 * (RW - 1 - k)));
      take[k] = rem_r[k] >= cand[k];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r[0] <= CW'(r2_r);
      res_r[0] <= '0;
      sq_r[0]  <= sq4;
      for (int k = 0; k < RW; k++) begin
        rem_r[k+1] <= take[k] ? rem_r[k] - cand[k] : rem_r[k];
        res_r[k+1] <= res_r[k] | (RW'(take[k]) << (RW - 1 - k));
        sq_r[k+1]  <= sq_r[k];
      end
    end
  end

  // stage a: r^2, numerators
  logic [RW-1:0]   root;
  sq_t             sqa;
  logic [2*RW-1:0] rsq_a_r;
  logic [RW-1:0]   r_a_r;
  logic [SW+W-1:0] nax_a_r, nay_a_r;
  logic [2*W-1:0]  fhx_a_r, flx_a_r, fhy_a_r, fly_a_r;
  logic [R2W-1:0]  r2_a_r;
  side_t           side_a_r;

  assign root = res_r[RW];
  assign sqa  = sq_r[RW];

  always_ff @(posedge clk) begin
    if (adv) begin
      rsq_a_r  <= root * root;
      r_a_r    <= root;
      nax_a_r  <= strength_r * sqa.adx;
      nay_a_r  <= strength_r * sqa.ady;
      fhx_a_r  <= sqa.fm[2*W-1:W] * sqa.adx;
      flx_a_r  <= sqa.fm[W-1:0] * sqa.adx;
      fhy_a_r  <= sqa.fm[2*W-1:W] * sqa.ady;
      fly_a_r  <= sqa.fm[W-1:0] * sqa.ady;
      r2_a_r   <= sqa.r2;
      side_a_r <= sqa.side;
    end
  end

  // stage b: r^3 partial products, reflection numerators
  logic [3*W-1:0]  fsum_x, fsum_y;
  logic [2*RW-1:0] dhi_b_r, dlo_b_r;
  logic [NRW-1:0]  nrx_b_r, nry_b_r;
  logic [SW+W-1:0] nax_b_r, nay_b_r;
  logic [R2W-1:0]  r2_b_r;
  side_t           side_b_r;

  assign fsum_x = {fhx_a_r, {W{1'b0}}} + {{W{1'b0}}, flx_a_r};
  assign fsum_y = {fhy_a_r, {W{1'b0}}} + {{W{1'b0}}, fly_a_r};

  always_ff @(posedge clk) begin
    if (adv) begin
      dhi_b_r  <= rsq_a_r[2*RW-1:RW] * r_a_r;
      dlo_b_r  <= rsq_a_r[RW-1:0] * r_a_r;
      nrx_b_r  <= {fsum_x, 1'b0};
      nry_b_r  <= {fsum_y, 1'b0};
      nax_b_r  <= nax_a_r;
      nay_b_r  <= nay_a_r;
      r2_b_r   <= r2_a_r;
      side_b_r <= side_a_r;
    end
  end

  // stage c: r^3 and scaled acceleration numerators
  logic [3*RW-1:0] den_c_r;
  logic [NAW-1:0]  nax_c_r, nay_c_r;
  logic [NRW-1:0]  nrx_c_r, nry_c_r;
  logic [R2W-1:0]  r2_c_r;
  side_t           side_c_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      den_c_r  <= {dhi_b_r, {RW{1'b0}}} + {{RW{1'b0}}, dlo_b_r};
      nax_c_r  <= NAW'(nax_b_r) << (3 * FRAC_BITS);
      nay_c_r  <= NAW'(nay_b_r) << (3 * FRAC_BITS);
      nrx_c_r  <= nrx_b_r;
      nry_c_r  <= nry_b_r;
      r2_c_r   <= r2_b_r;
      side_c_r <= side_b_r;
    end
  end

  // dividers
  logic [QW-1:0] qax, qay, qrx, qry;
  logic          oax, oay, orx, ory;

  cgb_div #(.NUM_W(NAW), .DEN_W(3 * RW), .QUO_W(QW)) u_div_ax (
    .clk(clk), .en(adv), .num(nax_c_r), .den(den_c_r), .quo(qax), .ovf(oax)
  );
  cgb_div #(.NUM_W(NAW), .DEN_W(3 * RW), .QUO_W(QW)) u_div_ay (
    .clk(clk), .en(adv), .num(nay_c_r), .den(den_c_r), .quo(qay), .ovf(oay)
  );
  cgb_div #(.NUM_W(NRW), .DEN_W(R2W), .QUO_W(QW)) u_div_rx (
    .clk(clk), .en(adv), .num(nrx_c_r), .den(r2_c_r), .quo(qrx), .ovf(orx)
  );
  cgb_div #(.NUM_W(NRW), .DEN_W(R2W), .QUO_W(QW)) u_div_ry (
    .clk(clk), .en(adv), .num(nry_c_r), .den(r2_c_r), .quo(qry), .ovf(ory)
  );

  side_t sd_r [0:QW];

  always_ff @(posedge clk) begin
    if (adv) begin
      sd_r[0] <= side_c_r;
      for (int j = 1; j <= QW; j++) begin
        sd_r[j] <= sd_r[j-1];
      end
    end
  end

  // result stage
  function automatic satv_t accel_fn(logic [QW-1:0] q, logic ovf, logic neg);
    satv_t        o;
    logic [QW-1:0] half;
    half  = QW'(1) << (W - 1);
    o.sat = ovf || (neg ? (q > half) : (q >= half));
    if (o.sat) begin
      o.val = neg ? SMIN : SMAX;
    end else begin
      o.val = neg ? (~q[W-1:0] + W'(1)) : q[W-1:0];
    end
    return o;
  endfunction

  function automatic satv_t refl_fn(logic [W-1:0] v, logic [QW-1:0] t, logic ovf,
                                    logic sub);
    satv_t      o;
    logic [W+2:0] ve, te, s;
    ve    = {{3{v[W-1]}}, v};
    te    = {2'b00, t};
    s     = sub ? ve - te : ve + te;
    o.sat = ovf || !((s[W+2:W-1] == 4'b0000) || (s[W+2:W-1] == 4'b1111));
    if (ovf) begin
      o.val = sub ? SMIN : SMAX;
    end else if (o.sat) begin
      o.val = s[W+2] ? SMIN : SMAX;
    end else begin
      o.val = s[W-1:0];
    end
    return o;
  endfunction

  side_t sdo;
  satv_t acx, acy, rfx, rfy;

  assign sdo = sd_r[QW];
  assign acx = accel_fn(qax, oax, sdo.x_neg);
  assign acy = accel_fn(qay, oay, sdo.y_neg);
  assign rfx = refl_fn(sdo.vx, qrx, orx, sdo.x_pos);
  assign rfy = refl_fn(sdo.vy, qry, ory, sdo.y_pos);

  logic signed [W-1:0] ax_r, ay_r, vx_r, vy_r;
  logic                bounced_r, inside_r, sat_r, last_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      last_r <= sdo.last;
      if (!central_mode_r) begin
        ax_r      <= const_gx_r;
        ay_r      <= const_gy_r;
        vx_r      <= sdo.vx;
        vy_r      <= sdo.vy;
        bounced_r <= 1'b0;
        inside_r  <= 1'b0;
        sat_r     <= 1'b0;
      end else begin
        ax_r      <= sdo.in_core ? '0 : acx.val;
        ay_r      <= sdo.in_core ? '0 : acy.val;
        vx_r      <= sdo.bounce ? rfx.val : sdo.vx;
        vy_r      <= sdo.bounce ? rfy.val : sdo.vy;
        bounced_r <= sdo.bounce;
        inside_r  <= sdo.in_core;
        sat_r     <= (!sdo.in_core && (acx.sat || acy.sat)) ||
                     (sdo.bounce && (rfx.sat || rfy.sat));
      end
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.accel_x     = ax_r;
  assign out_ch.accel_y     = ay_r;
  assign out_ch.out_vx      = vx_r;
  assign out_ch.out_vy      = vy_r;
  assign out_ch.bounced     = bounced_r;
  assign out_ch.inside_core = inside_r;
  assign out_ch.saturated   = sat_r;
  assign out_ch.last_out    = last_r;

  a_inside_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && inside_r |-> (ax_r == '0) && (ay_r == '0))
    else $error("acceleration not zero inside core");

  a_const_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !central_mode_r |-> !bounced_r && !inside_r && !sat_r)
    else $error("status flag set in constant mode");

  a_sat_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && sat_r && !bounced_r |->
      (ax_r == SMAX) || (ax_r == SMIN) || (ay_r == SMAX) || (ay_r == SMIN))
    else $error("saturation flag without clamped acceleration");

endmodule

// ===== test/central_gravity_and_bounce_test.sv =====
// testbench for central_gravity_and_bounce: predicted results checked per transaction
`timescale 1ns / 1ps

module central_gravity_and_bounce_test;
  import cgb_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
  localparam int DRAIN_CYCLES = 80;
  localparam int IDLE_LIMIT = 3000;
  localparam logic signed [23:0] WORD_MAX = 24'sh7fffff;
  localparam logic signed [23:0] WORD_MIN = 24'sh800000;
  localparam logic [22:0] UMAX = 23'h7fffff;

  typedef struct {
    logic signed [23:0] x, y, vx, vy;
    logic [22:0] rad;
    logic last;
  } ball_t;

  typedef struct {
    logic signed [23:0] ax, ay, vx, vy;
    logic bounced, in_core, sat, last;
  } motion_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  cgb_in_if #(.WORD_WIDTH(24)) in_ch ();
  cgb_out_if #(.WORD_WIDTH(24)) out_ch ();

  central_gravity_and_bounce dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .in_ch(in_ch), .out_ch(out_ch)
  );

  // field settings as the block holds them
  logic field_central;
  logic signed [23:0] field_gx, field_gy;
  logic [22:0] field_core, field_cx, field_cy;
  logic [31:0] field_strength;

  motion_t pending_motion[$];
  int error_count;
  int idle_cycles;
  int stall_left;
  bit steady;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [23:0] clamp_word(input logic signed [127:0] s, inout logic flag);
    if (s > 128'sd8388607) begin
      flag = 1'b1;
      return WORD_MAX;
    end
    if (s < -128'sd8388608) begin
      flag = 1'b1;
      return WORD_MIN;
    end
    return s[23:0];
  endfunction

  function automatic logic [127:0] floor_root(input logic [127:0] n);
    logic [127:0] root, trial;
    root = '0;
    for (int b = 40; b >= 0; b--) begin
      trial = root | (128'd1 << b);
      if (n >= trial * trial) root = trial;
    end
    return root;
  endfunction

  function automatic motion_t ball_motion(input ball_t b);
    motion_t m;
    logic signed [127:0] px, py, vx, vy, dx, dy, f, tx, ty;
    logic [127:0] adx, ady, r2, r, den, rr, core, qx, qy, fm;
    m = '{ax: '0, ay: '0, vx: b.vx, vy: b.vy, bounced: 1'b0, in_core: 1'b0,
          sat: 1'b0, last: b.last};
    if (!field_central) begin
      m.ax = field_gx;
      m.ay = field_gy;
      return m;
    end
    px = b.x;
    py = b.y;
    vx = b.vx;
    vy = b.vy;
    dx = $signed(128'(field_cx)) - px;
    dy = $signed(128'(field_cy)) - py;
    adx = dx < 0 ? $unsigned(-dx) : $unsigned(dx);
    ady = dy < 0 ? $unsigned(-dy) : $unsigned(dy);
    r2 = adx * adx + ady * ady;
    core = 128'(field_core);
    rr = 128'(b.rad) + core;
    if (r2 < core * core || r2 == 0) begin
      m.in_core = 1'b1;
    end else begin
      r = floor_root(r2);
      den = r * r * r;
      qx = ((128'(field_strength) * adx) << 24) / den;
      qy = ((128'(field_strength) * ady) << 24) / den;
      m.ax = clamp_word(dx < 0 ? -$signed(qx) : $signed(qx), m.sat);
      m.ay = clamp_word(dy < 0 ? -$signed(qy) : $signed(qy), m.sat);
    end
    if (rr * rr >= r2) begin
      // inward motion: v points against centre-to-ball direction
      f = -(vx * dx + vy * dy);
      if (f < 0 && r2 != 0) begin
        fm = $unsigned(-f);
        tx = $signed((fm * adx * 2) / r2);
        ty = $signed((fm * ady * 2) / r2);
        m.vx = clamp_word(dx > 0 ? vx - tx : vx + tx, m.sat);
        m.vy = clamp_word(dy > 0 ? vy - ty : vy + ty, m.sat);
        m.bounced = 1'b1;
      end
    end
    return m;
  endfunction

  function automatic int pick_gap();
    int pick;
    if (steady) return 0;
    pick = $urandom_range(0, 19);
    if (pick == 0) return $urandom_range(8, 40);
    if (pick <= 5) return $urandom_range(1, 3);
    return 0;
  endfunction

  function automatic logic signed [23:0] rand_word();
    logic signed [23:0] w;
    w = 24'($urandom);
    return w >>> $urandom_range(0, 23);
  endfunction

  function automatic ball_t make_ball(input logic signed [23:0] x, y, vx, vy,
                                      input logic [22:0] rad, input logic last);
    ball_t b;
    b = '{x: x, y: y, vx: vx, vy: vy, rad: rad, last: last};
    return b;
  endfunction

  function automatic ball_t noise_ball();
    return make_ball(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                     23'($urandom), 1'($urandom));
  endfunction

  // ball placed around the core so that touching and bouncing are common
  function automatic ball_t near_ball();
    longint rad, reach, ox, oy;
    rad = field_core == 0 ? $urandom_range(0, 4000) : $urandom_range(0, int'(field_core));
    if ($urandom_range(0, 7) == 0) rad = $urandom_range(0, 255);
    reach = longint'(field_core) + rad + $urandom_range(0, 1024);
    ox = longint'($urandom_range(0, 32'(2 * reach))) - reach;
    oy = longint'($urandom_range(0, 32'(2 * reach))) - reach;
    return make_ball(24'(longint'(field_cx) - ox), 24'(longint'(field_cy) - oy),
                     rand_word(), rand_word(), 23'(rad), 1'($urandom));
  endfunction

  task automatic send_ball(input ball_t b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.ball_x <= b.x;
    in_ch.ball_y <= b.y;
    in_ch.ball_vx <= b.vx;
    in_ch.ball_vy <= b.vy;
    in_ch.ball_radius <= b.rad;
    in_ch.last_ball <= b.last;
    do @(posedge clk); while (!in_ch.ready);
    pending_motion.push_back(ball_motion(b));
  endtask

  task automatic send_random(input int count, input int near_pct);
    for (int i = 0; i < count; i++) begin
      if (i % 60 == 0) steady = ($urandom_range(0, 3) == 0);
      if (field_central && $urandom_range(0, 99) < near_pct) send_ball(near_ball());
      else send_ball(noise_ball());
    end
    steady = 1'b0;
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_motion.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      CFG_CENTRAL_MODE: field_central = data[0];
      CFG_CONST_GX: field_gx = data[23:0];
      CFG_CONST_GY: field_gy = data[23:0];
      CFG_CORE_RADIUS: field_core = data[22:0];
      CFG_STRENGTH: field_strength = data;
      CFG_CENTER_X: field_cx = data[22:0];
      CFG_CENTER_Y: field_cy = data[22:0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic mode, input logic signed [23:0] gx, gy,
                           input logic [22:0] core, input logic [31:0] strength,
                           input logic [22:0] cx, cy);
    cfg_write(CFG_CENTRAL_MODE, 32'(mode));
    cfg_write(CFG_CONST_GX, 32'($unsigned(gx)));
    cfg_write(CFG_CONST_GY, 32'($unsigned(gy)));
    cfg_write(CFG_CORE_RADIUS, 32'(core));
    cfg_write(CFG_STRENGTH, strength);
    cfg_write(CFG_CENTER_X, 32'(cx));
    cfg_write(CFG_CENTER_Y, 32'(cy));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_reset_constant_field();
    send_ball(make_ball(WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, UMAX, 1'b1));
    send_ball(make_ball(WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, '0, 1'b0));
    send_random(150, 0);
    settle();
  endtask

  task automatic test_constant_extremes();
    configure(1'b0, WORD_MIN, WORD_MAX, UMAX, 32'hffffffff, UMAX, UMAX);
    send_random(100, 0);
    settle();
    configure(1'b0, WORD_MAX, WORD_MIN, '0, '0, '0, '0);
    send_random(100, 0);
    settle();
  endtask

  task automatic test_central_default();
    configure(1'b1, '0, 24'(CONST_GY_RST), 23'(CORE_RADIUS_RST), STRENGTH_RST,
              23'(CENTER_X_RST), 23'(CENTER_Y_RST));
    // centre, core edge, touching inward and outward, far away
    send_ball(make_ball(24'(CENTER_X_RST), 24'(CENTER_Y_RST), 24'sd100, 24'sd0, 23'd256, 1'b0));
    send_ball(make_ball(24'(CENTER_X_RST + CORE_RADIUS_RST), 24'(CENTER_Y_RST),
                        -24'sd512, 24'sd300, 23'd0, 1'b0));
    send_ball(make_ball(24'(CENTER_X_RST - CORE_RADIUS_RST - 1000), 24'(CENTER_Y_RST - 500),
                        24'sd2000, 24'sd700, 23'd2000, 1'b1));
    send_ball(make_ball(24'(CENTER_X_RST - CORE_RADIUS_RST - 1000), 24'(CENTER_Y_RST - 500),
                        -24'sd2000, -24'sd700, 23'd2000, 1'b0));
    send_ball(make_ball(24'(CENTER_X_RST + 3000), 24'(CENTER_Y_RST + CORE_RADIUS_RST),
                        WORD_MIN, WORD_MIN, UMAX, 1'b0));
    send_ball(make_ball(WORD_MIN, WORD_MAX, WORD_MAX, WORD_MIN, '0, 1'b1));
    send_ball(make_ball(WORD_MAX, WORD_MIN, '0, '0, UMAX, 1'b0));
    send_random(400, 80);
    settle();
  endtask

  task automatic test_zero_core_saturation();
    configure(1'b1, '0, '0, '0, 32'hffffffff, 23'd1000, 23'd1000);
    send_ball(make_ball(24'sd1000, 24'sd1000, 24'sd77, -24'sd5, 23'd0, 1'b1));
    send_ball(make_ball(24'sd1001, 24'sd1000, -24'sd10, 24'sd0, 23'd4, 1'b0));
    send_ball(make_ball(24'sd1000, 24'sd999, WORD_MAX, WORD_MAX, UMAX, 1'b0));
    send_ball(make_ball(24'sd990, 24'sd1003, WORD_MAX, WORD_MIN, UMAX, 1'b0));
    send_random(250, 85);
    settle();
  endtask

  task automatic test_register_extremes();
    configure(1'b1, WORD_MAX, WORD_MIN, UMAX, 32'hffffffff, UMAX, UMAX);
    send_ball(make_ball(WORD_MIN, WORD_MIN, WORD_MAX, WORD_MAX, UMAX, 1'b1));
    send_ball(make_ball(WORD_MAX, WORD_MAX, '0, '0, '0, 1'b0));
    send_random(80, 70);
    settle();
    configure(1'b1, '0, '0, UMAX, '0, '0, '0);
    send_ball(make_ball(WORD_MAX, WORD_MAX, WORD_MIN, WORD_MIN, UMAX, 1'b0));
    send_random(80, 70);
    settle();
    configure(1'b1, '0, '0, 23'd1, 32'd1, '0, UMAX);
    send_random(80, 70);
    settle();
  endtask

  task automatic test_ignored_index();
    cfg_write(CFG_UNUSED, 32'hffffffff);
    cfg_we <= 1'b0;
    @(posedge clk);
    send_random(40, 70);
    settle();
  endtask

  task automatic test_random_fields();
    for (int phase = 0; phase < 4; phase++) begin
      configure(1'($urandom), rand_word(), rand_word(), 23'($urandom_range(0, 40000)),
                $urandom >> $urandom_range(0, 31), 23'($urandom), 23'($urandom));
      send_random(115, 75);
      settle();
    end
  endtask

  task automatic check_field(input string name, input logic [23:0] want, got);
    if (want !== got) begin
      $error("%s expected %0h got %0h", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    motion_t m;
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("central_gravity_and_bounce_test failed");
        $finish;
      end
    end
    if (out_ch.valid && out_ch.ready) begin
      if (pending_motion.size() == 0) begin
        $error("result transaction with nothing expected");
        error_count++;
      end else begin
        m = pending_motion.pop_front();
        check_field("accel_x", m.ax, out_ch.accel_x);
        check_field("accel_y", m.ay, out_ch.accel_y);
        check_field("out_vx", m.vx, out_ch.out_vx);
        check_field("out_vy", m.vy, out_ch.out_vy);
        check_field("bounced", 24'(m.bounced), 24'(out_ch.bounced));
        check_field("inside_core", 24'(m.in_core), 24'(out_ch.inside_core));
        check_field("saturated", 24'(m.sat), 24'(out_ch.saturated));
        check_field("last_out", 24'(m.last), 24'(out_ch.last_out));
      end
    end
    if (steady) begin
      out_ch.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else begin
      case ($urandom_range(0, 19))
        0: stall_left = $urandom_range(8, 40);
        1, 2, 3, 4: stall_left = $urandom_range(1, 3);
        default: stall_left = 0;
      endcase
      out_ch.ready <= (stall_left == 0);
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.ball_x = '0;
    in_ch.ball_y = '0;
    in_ch.ball_vx = '0;
    in_ch.ball_vy = '0;
    in_ch.ball_radius = '0;
    in_ch.last_ball = 1'b0;
    out_ch.ready = 1'b0;
    error_count = 0;
    idle_cycles = 0;
    stall_left = 0;
    steady = 1'b0;
    field_central = 1'b0;
    field_gx = '0;
    field_gy = 24'(CONST_GY_RST);
    field_core = 23'(CORE_RADIUS_RST);
    field_strength = STRENGTH_RST;
    field_cx = 23'(CENTER_X_RST);
    field_cy = 23'(CENTER_Y_RST);
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_constant_field();
    test_constant_extremes();
    test_central_default();
    test_zero_core_saturation();
    test_register_extremes();
    test_ignored_index();
    test_random_fields();
    if (error_count == 0) begin
      $display("central_gravity_and_bounce_test passed");
    end else begin
      $display("central_gravity_and_bounce_test failed");
    end
    $finish;
  end

endmodule
